[src/etbr_pkg.sv]
// ----------------------------------------------------------------------------
// etbr_pkg
// Types and constants shared by the edge timing bit recovery block.
// ----------------------------------------------------------------------------
package etbr_pkg;

  localparam int CAPTURE_W = 32;
  localparam int PERIOD_W  = 17;
  localparam int HALF_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = PERIOD_W;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 17'd66667;
  localparam logic [HALF_W-1:0]   HALF_PERIOD_RST = 16'd33333;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_PERIOD = 1'd1;

  localparam logic STATUS_BIT      = 1'b0;
  localparam logic STATUS_SYNC_ERR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAP,
    ST_LIMIT,
    ST_LOOP
  } etbr_state_t;

  typedef struct packed {
    logic take_in;
    logic sync_err;
    logic calc_gap;
    logic load_loop;
    logic emit_bit;
    logic finish;
  } etbr_cmd_t;

  typedef struct packed {
    logic fault;
    logic over_limit;
    logic bit_due;
    logic out_free;
  } etbr_sts_t;

endpackage

[src/etbr_if.sv]
// ----------------------------------------------------------------------------
// etbr_if
// Handshake channels of the edge timing bit recovery block.
// ----------------------------------------------------------------------------
interface etbr_edge_if;
  logic                           valid;
  logic                           ready;
  logic [etbr_pkg::CAPTURE_W-1:0] capture_word;
  logic                           capture_error;

  modport source (output valid, output capture_word, output capture_error, input ready);
  modport sink   (input valid, input capture_word, input capture_error, output ready);
endinterface

interface etbr_bit_if;
  logic valid;
  logic ready;
  logic status;
  logic bit_value;
  logic last;

  modport source (output valid, output status, output bit_value, output last, input ready);
  modport sink   (input valid, input status, input bit_value, input last, output ready);
endinterface

[src/edge_timing_bit_recovery_nrzi.sv]
// ----------------------------------------------------------------------------
// edge_timing_bit_recovery_nrzi
// Slices edge timestamps into bit periods and emits NRZI-decoded bits.
// ----------------------------------------------------------------------------
// The in_edge channel takes one capture word per line edge: a free-running
// timestamp whose bit 0 gives the polarity, and a capture error flag. The
// out_bit channel gives the results of that edge in order: a recovered bit
// with status 0, or a single sync error with status 1. The final result of
// an edge carries last. An edge that completes no bit period gives nothing.
// An accepted item is checked for errors and polarity in the next cycle and
// against the gap limit in the one after; a sync error is then registered.
// After that the shared phase and period adder slices one bit period per
// cycle while the receiver takes the bits, up to MAX_GAP_BITS per edge. The
// block takes a new edge only between items. When the receiver stalls, the
// result register holds and the sequencer waits before the next bit. Reset
// restores the default bit period and threshold, clears the timing state
// and sets the previous level to one. The user must write registers via the
// cfg port only while no item is in progress; the block does not check.
// ----------------------------------------------------------------------------
module edge_timing_bit_recovery_nrzi #(
  parameter int MAX_GAP_BITS = 32,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [etbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  etbr_edge_if.sink                       in_edge,
  etbr_bit_if.source                      out_bit
);

  etbr_pkg::etbr_cmd_t cmd;
  etbr_pkg::etbr_sts_t sts;

  etbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_edge.valid),
    .in_ready (in_edge.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etbr_datapath #(
    .MAX_GAP_BITS (MAX_GAP_BITS),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_capture_word  (in_edge.capture_word),
    .in_capture_error (in_edge.capture_error),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_bit.valid),
    .out_ready        (out_bit.ready),
    .out_status       (out_bit.status),
    .out_bit_value    (out_bit.bit_value),
    .out_last         (out_bit.last)
  );

endmodule

[src/etbr_ctrl.sv]
// ----------------------------------------------------------------------------
// etbr_ctrl
// Sequencer that steps one edge item through check, limit and bit slicing.
// ----------------------------------------------------------------------------
module etbr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  etbr_pkg::etbr_sts_t sts,
  output etbr_pkg::etbr_cmd_t cmd
);

  etbr_pkg::etbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etbr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      etbr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = etbr_pkg::ST_GAP;
      end
      etbr_pkg::ST_GAP: begin
        if (!sts.fault) begin
          state_nxt = etbr_pkg::ST_LIMIT;
        end else if (sts.out_free) begin
          state_nxt = etbr_pkg::ST_IDLE;
        end
      end
      etbr_pkg::ST_LIMIT: begin
        if (!sts.over_limit) begin
          state_nxt = etbr_pkg::ST_LOOP;
        end else if (sts.out_free) begin
          state_nxt = etbr_pkg::ST_IDLE;
        end
      end
      etbr_pkg::ST_LOOP: begin
        if (!sts.bit_due) state_nxt = etbr_pkg::ST_IDLE;
      end
      default: state_nxt = etbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      etbr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      etbr_pkg::ST_GAP: begin
        cmd.calc_gap = !sts.fault;
        cmd.sync_err = sts.fault && sts.out_free;
      end
      etbr_pkg::ST_LIMIT: begin
        cmd.load_loop = !sts.over_limit;
        cmd.sync_err  = sts.over_limit && sts.out_free;
      end
      etbr_pkg::ST_LOOP: begin
        cmd.emit_bit = sts.bit_due && sts.out_free;
        cmd.finish   = !sts.bit_due;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/etbr_datapath.sv]
// ----------------------------------------------------------------------------
// etbr_datapath
// Timing state, shared phase and period unit, and the result register.
// ----------------------------------------------------------------------------
module etbr_datapath #(
  parameter int MAX_GAP_BITS = 32,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [etbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [etbr_pkg::CAPTURE_W-1:0]   in_capture_word,
  input  logic                             in_capture_error,
  input  etbr_pkg::etbr_cmd_t              cmd,
  output etbr_pkg::etbr_sts_t              sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic                             out_bit_value,
  output logic                             out_last
);

  localparam int PW = etbr_pkg::PERIOD_W;
  localparam int HW = etbr_pkg::HALF_W;
  localparam int TW = TIME_WIDTH;
  localparam int GW = PW + $clog2(MAX_GAP_BITS);
  localparam int SW = GW + 1;
  localparam int CW = (TW > GW) ? TW : GW;

  logic [PW-1:0] bit_period_r;
  logic [HW-1:0] half_period_r;
  logic [GW-1:0] limit_r;
  logic [TW-1:0] word_r;
  logic          err_r;
  logic [TW-1:0] last_edge_r;
  logic [TW-1:0] gap_full_r;
  logic [GW-1:0] gap_r;
  logic [PW-1:0] phase_r;
  logic [PW-1:0] bit_phase_r;
  logic [PW-1:0] high_time_r;
  logic          prev_level_r;
  logic          out_valid_r;
  logic          out_status_r;
  logic          out_bit_value_r;
  logic          out_last_r;

  logic [PW-1:0] period_eff;
  logic [SW-1:0] sum;
  logic [SW-1:0] rem;
  logic [PW-1:0] add;
  logic [PW:0]   ht_sum;
  logic          level;
  logic          high;
  logic          out_free;

  assign period_eff = (bit_period_r == '0) ? PW'(1) : bit_period_r;
  assign high       = word_r[0];
  assign sum        = SW'(phase_r) + SW'(gap_r);
  assign rem        = sum - SW'(period_eff);
  assign add        = period_eff - phase_r;
  assign ht_sum     = {1'b0, high_time_r} + (high ? {1'b0, add} : '0);
  assign level      = (ht_sum >= (PW+1)'(half_period_r));
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    sts.fault      = err_r || (word_r[0] == last_edge_r[0]);
    sts.over_limit = CW'(gap_full_r) > CW'(limit_r);
    sts.bit_due    = sum >= SW'(period_eff);
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= etbr_pkg::BIT_PERIOD_RST;
      half_period_r <= etbr_pkg::HALF_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        etbr_pkg::REG_BIT_PERIOD:      bit_period_r  <= cfg_wdata;
        etbr_pkg::REG_HALF_BIT_PERIOD: half_period_r <= cfg_wdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= GW'(period_eff) * GW'(MAX_GAP_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      word_r <= TW'(in_capture_word);
      err_r  <= in_capture_error;
    end
    if (cmd.calc_gap) begin
      gap_full_r <= word_r - last_edge_r;
    end
    if (cmd.load_loop) begin
      gap_r   <= GW'(gap_full_r);
      phase_r <= (bit_phase_r >= period_eff) ? period_eff - PW'(1) : bit_phase_r;
    end else if (cmd.emit_bit) begin
      gap_r   <= GW'(rem);
      phase_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r  <= '0;
      bit_phase_r  <= '0;
      high_time_r  <= '0;
      prev_level_r <= 1'b1;
    end else begin
      if (cmd.calc_gap) begin
        last_edge_r <= word_r;
      end
      if (cmd.emit_bit) begin
        high_time_r  <= '0;
        prev_level_r <= level;
      end else if (cmd.finish) begin
        bit_phase_r <= sum[PW-1:0];
        if (high) high_time_r <= high_time_r + gap_r[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sync_err || cmd.emit_bit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sync_err) begin
      out_status_r    <= etbr_pkg::STATUS_SYNC_ERR;
      out_bit_value_r <= 1'b0;
      out_last_r      <= 1'b1;
    end else if (cmd.emit_bit) begin
      out_status_r    <= etbr_pkg::STATUS_BIT;
      out_bit_value_r <= (level == prev_level_r);
      out_last_r      <= (rem < SW'(period_eff));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bit_value = out_bit_value_r;
  assign out_last      = out_last_r;

endmodule

[src/etbr_checker.sv]
// ----------------------------------------------------------------------------
// etbr_checker
// Port-level checks of the edge timing bit recovery block.
// ----------------------------------------------------------------------------
module etbr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic out_bit_value,
  input logic out_last
);

  a_sync_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_bit_value && out_last)
    else $error("sync error item without last or with a data bit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_status, out_bit_value, out_last}))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind edge_timing_bit_recovery_nrzi etbr_checker u_etbr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_edge.valid),
  .in_ready      (in_edge.ready),
  .out_valid     (out_bit.valid),
  .out_ready     (out_bit.ready),
  .out_status    (out_bit.status),
  .out_bit_value (out_bit.bit_value),
  .out_last      (out_bit.last)
);

[tb/sv/edge_timing_bit_recovery_nrzi_test.sv]
// ----------------------------------------------------------------------------
// edge_timing_bit_recovery_nrzi_test
// Self-checking testbench for the edge timing bit recovery block.
// ----------------------------------------------------------------------------
// Edge items are driven on the in_edge channel and every recovered bit or
// sync error on the out_bit channel is checked against a cycle-free slicer
// model kept in this file. Directed items cover short intervals, repeated
// polarity, capture errors, the gap limit, timestamp wraparound and the
// register extremes, including a phase left beyond a shortened period.
// Random traffic follows under three idle patterns on both channels.
// ----------------------------------------------------------------------------
module edge_timing_bit_recovery_nrzi_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned GAP_BITS   = 32;
  localparam int              SETTLE     = 40;
  localparam int              LIMIT      = 400000;

  typedef struct packed {
    logic status;
    logic bit_value;
    logic last;
  } bit_result_t;

  localparam bit_result_t SYNC_RESULT = '{etbr_pkg::STATUS_SYNC_ERR, 1'b0, 1'b1};

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [etbr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [etbr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  etbr_edge_if edge_ch ();
  etbr_bit_if  bit_ch ();

  edge_timing_bit_recovery_nrzi dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_edge   (edge_ch),
    .out_bit   (bit_ch)
  );

  bit_result_t     expected_bits[$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct;
  int              recv_idle_pct;

  logic [etbr_pkg::PERIOD_W-1:0] period_reg    = etbr_pkg::BIT_PERIOD_RST;
  logic [etbr_pkg::HALF_W-1:0]   threshold_reg = etbr_pkg::HALF_PERIOD_RST;
  logic [31:0]                   stamp_prev    = '0;
  longint unsigned               phase_acc     = 0;
  longint unsigned               high_acc      = 0;
  logic                          last_level    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    bit_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_bits
    bit_result_t want;
    if (rst_n && bit_ch.valid && bit_ch.ready) begin
      if (expected_bits.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_bits.pop_front();
        if (bit_ch.status !== want.status)
          report_mismatch($sformatf("status %b, expected %b", bit_ch.status, want.status));
        if (bit_ch.bit_value !== want.bit_value)
          report_mismatch($sformatf("bit_value %b, expected %b", bit_ch.bit_value,
                                    want.bit_value));
        if (bit_ch.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", bit_ch.last, want.last));
      end
    end
  end

  // Cuts the interval since the previous edge at bit-period boundaries.
  task automatic slice_edge(input logic [31:0] word, input logic err);
    bit_result_t     res;
    logic [31:0]     delta;
    longint unsigned period, gap, phase, span;
    logic            high, level;
    period = (period_reg == '0) ? 1 : period_reg;
    delta = word - stamp_prev;
    if (err || (word[0] == stamp_prev[0])) begin
      expected_bits.push_back(SYNC_RESULT);
      return;
    end
    stamp_prev = word;
    gap = delta;
    if (gap > GAP_BITS * period) begin
      expected_bits.push_back(SYNC_RESULT);
      return;
    end
    high = word[0];
    phase = (phase_acc >= period) ? period - 1 : phase_acc;
    while (phase + gap >= period) begin
      span = period - phase;
      if (high) high_acc += span;
      gap -= span;
      level = (high_acc >= threshold_reg);
      high_acc = 0;
      phase = 0;
      res.status = etbr_pkg::STATUS_BIT;
      res.bit_value = (level == last_level);
      res.last = (gap < period);
      expected_bits.push_back(res);
      last_level = level;
    end
    if (high) high_acc = (high_acc + gap) & 64'h1FFFF;
    phase_acc = (phase + gap) & 64'h1FFFF;
  endtask

  task automatic send_edge(input logic [31:0] word, input logic err);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      edge_ch.valid <= 1'b0;
    end
    @(negedge clk);
    edge_ch.valid <= 1'b1;
    edge_ch.capture_word <= word;
    edge_ch.capture_error <= err;
    do @(posedge clk); while (!edge_ch.ready);
    slice_edge(word, err);
  endtask

  task automatic send_gap(input longint unsigned gap, input logic err);
    send_edge(stamp_prev + gap[31:0], err);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    edge_ch.valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [etbr_pkg::CFG_IDX_W-1:0] index,
                           input logic [etbr_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == etbr_pkg::REG_BIT_PERIOD) period_reg = data[etbr_pkg::PERIOD_W-1:0];
    else threshold_reg = data[etbr_pkg::HALF_W-1:0];
  endtask

  task automatic test_default_slicing();
    longint unsigned p;
    p = period_reg;
    send_gap(1, 1'b0);
    send_gap(0, 1'b0);
    send_gap(5, 1'b1);
    send_gap(p, 1'b0);
    send_gap(3 * p, 1'b0);
    send_gap(GAP_BITS * p - 1, 1'b0);
    send_gap(GAP_BITS * p + 1, 1'b0);
    send_edge(32'hFFFF_FFFF, 1'b0);
    send_edge(32'h0000_0000, 1'b0);
    send_edge(32'hFFFF_FFFF, 1'b0);
    send_edge(32'h0000_0002, 1'b0);
  endtask

  task automatic test_register_extremes();
    cfg_write(etbr_pkg::REG_BIT_PERIOD, '0);
    cfg_write(etbr_pkg::REG_HALF_BIT_PERIOD, '0);
    send_gap(31, 1'b0);
    send_gap(1, 1'b0);
    send_gap(33, 1'b0);
    cfg_write(etbr_pkg::REG_HALF_BIT_PERIOD, 17'h0FFFF);
    send_gap(7, 1'b0);
    cfg_write(etbr_pkg::REG_BIT_PERIOD, 17'h1FFFF);
    send_gap(2 * 131071 + 1, 1'b0);
    send_gap(100001, 1'b0);
    // The phase now lies beyond the shorter period written next.
    cfg_write(etbr_pkg::REG_BIT_PERIOD, 17'd5);
    send_gap(1, 1'b0);
    cfg_write(etbr_pkg::REG_BIT_PERIOD, 17'd1);
    cfg_write(etbr_pkg::REG_HALF_BIT_PERIOD, 17'd1);
    send_gap(3, 1'b0);
  endtask

  task automatic configure_random();
    int unsigned p, h;
    case ($urandom_range(0, 3))
      0: begin
        p = $urandom_range(0, 16);
      end
      1: begin
        p = $urandom_range(17, 4096);
      end
      default: begin
        p = $urandom_range(4097, 131071);
      end
    endcase
    if ($urandom_range(0, 4) == 0) h = $urandom_range(0, 65535);
    else h = $urandom_range(0, (p > 65535) ? 65535 : p);
    cfg_write(etbr_pkg::REG_BIT_PERIOD, p[etbr_pkg::CFG_DATA_W-1:0]);
    cfg_write(etbr_pkg::REG_HALF_BIT_PERIOD, h[etbr_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic send_random_edge();
    longint unsigned period, gap;
    int              pick, k;
    period = (period_reg == '0) ? 1 : period_reg;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_edge($urandom, 1'b1);
    end else if (pick < 12) begin
      send_edge($urandom, 1'b0);
    end else if (pick < 16) begin
      send_gap(2 * $urandom_range(0, 2 * period), 1'b0);
    end else if (pick < 20) begin
      send_gap(GAP_BITS * period + 1 + 2 * $urandom_range(0, 1000), 1'b0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) k = $urandom_range(0, 3);
      else if (pick < 95) k = $urandom_range(4, 12);
      else k = $urandom_range(13, 31);
      gap = k * period + $urandom_range(0, period - 1);
      gap |= 1;
      if (gap >= GAP_BITS * period) gap = GAP_BITS * period - 1;
      send_gap(gap, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    configure_random();
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 4) wait_idle();
      send_random_edge();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    edge_ch.valid = 1'b0;
    edge_ch.capture_word = '0;
    edge_ch.capture_error = 1'b0;
    bit_ch.ready = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 84;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_slicing();
    test_register_extremes();
    test_random_traffic(30, 84, 34);
    test_random_traffic(84, 30, 34);
    test_random_traffic(0, 0, 34);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
